// ----- design/ddac_pkg.sv -----
// Shared types and constants for the DDA wall column caster.
package ddac_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_CAM_POS_X     = 3'd0;
  localparam logic [2:0] REG_CAM_POS_Y     = 3'd1;
  localparam logic [2:0] REG_VIEW_DIR_X    = 3'd2;
  localparam logic [2:0] REG_VIEW_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_CAM_PLANE_X   = 3'd4;
  localparam logic [2:0] REG_CAM_PLANE_Y   = 3'd5;
  localparam logic [2:0] REG_HORIZON_SHIFT = 3'd6;

  // Input operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Tile code that blocks a ray
  localparam logic [1:0] TILE_WALL = 2'd1;

  // Shared divider geometry
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 27;

  // Fixed widths of the datapath
  localparam int CAM_W = 24;
  localparam int RD_W  = 27;

  // Fixed-point limits
  localparam logic [23:0] MIN_DIST  = 24'd6554;
  localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
  localparam logic [11:0] LINE_MAX  = 12'd4095;
  localparam int          TEX_ROWS  = 64;
  localparam logic [32:0] SHADE_NUM_X = 33'd83558400;  // 255 * 5 * 65536
  localparam logic [32:0] SHADE_NUM_Y = 33'd58982400;  // 180 * 5 * 65536
  localparam logic [26:0] SHADE_BIAS  = 27'd327680;    // 5.0 in Q.16

  // Camera configuration set
  typedef struct packed {
    logic        [20:0] pos_x;
    logic        [20:0] pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
    logic signed [7:0]  horizon;
  } cam_cfg_t;

endpackage

// ----- design/ddac_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module ddac_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ddac_pkg::DIV_NW-1:0]  num,
  input  logic [ddac_pkg::DIV_DW-1:0]  den,
  output logic                         done,
  output logic [ddac_pkg::DIV_NW-1:0]  quot
);
  import ddac_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_NW-1:0] num_sh;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW:0]   trial;
  logic              fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem, num_sh[DIV_NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quot   <= '0;
    end else if (run) begin
      num_sh <= {num_sh[DIV_NW-2:0], 1'b0};
      rem    <= fits ? DIV_DW'(trial - {1'b0, den_r}) : trial[DIV_DW-1:0];
      quot   <= {quot[DIV_NW-2:0], fits};
    end
  end

endmodule

// ----- design/ddac_core.sv -----
// Cast sequencer: tile map, shared multiplier, grid walk and result shaping.
module ddac_core #(
  parameter int MAP_W     = 32,
  parameter int MAP_H     = 32,
  parameter int SCREEN_W  = 396,
  parameter int SCREEN_H  = 224,
  parameter int TEX_W     = 64,
  parameter int MAX_STEPS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ddac_pkg::cam_cfg_t cfg,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [9:0]         cell_addr,
  input  logic [1:0]         cell_tile,
  input  logic [8:0]         column,
  output logic               done,
  output logic [23:0]        wall_dist,
  output logic               wall_side,
  output logic               wall_found,
  output logic [5:0]         tex_column,
  output logic [11:0]        line_height,
  output logic [7:0]         top_row,
  output logic [7:0]         bottom_row,
  output logic [23:0]        tex_row_step,
  output logic signed [23:0] tex_row_start,
  output logic [7:0]         shade
);
  import ddac_pkg::*;

  localparam int CELLS     = MAP_W * MAP_H;
  localparam int MEM_DEPTH = (CELLS < 1024) ? CELLS : 1024;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int IT_W      = $clog2(MAX_STEPS + 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001, S_CAM  = 20'h00002, S_MPX  = 20'h00004,
    S_MPY   = 20'h00008, S_XGO  = 20'h00010, S_XDIV = 20'h00020,
    S_XMUL  = 20'h00040, S_XSD  = 20'h00080, S_YGO  = 20'h00100,
    S_YDIV  = 20'h00200, S_YMUL = 20'h00400, S_YSD  = 20'h00800,
    S_STEP  = 20'h01000, S_CHECK = 20'h02000, S_PERP = 20'h04000,
    S_LH    = 20'h08000, S_TSGO = 20'h10000, S_TS   = 20'h20000,
    S_SHGO  = 20'h40000, S_SH   = 20'h80000
  } state_t;

  state_t state;

  // Tile map
  logic [1:0]        tile_map [MEM_DEPTH];
  logic [1:0]        rd_tile;
  logic [MEM_AW-1:0] rd_idx;

  // Ray registers
  logic signed [CAM_W-1:0] cam;
  logic signed [RD_W-1:0]  rdx, rdy;
  logic [56:0]             ddx, ddy;
  logic [63:0]             sdx, sdy;
  logic signed [9:0]       mx, my;
  logic                    side, hit, oob;
  logic [IT_W-1:0]         iter;
  logic [23:0]             perp;
  logic [11:0]             lh;

  // Shared multiplier
  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [59:0] prod;

  // Divider hookup
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den;

  // Combinational helpers
  logic              rdx_neg, rdy_neg;
  logic [RD_W-1:0]   magx, magy;
  logic [16:0]       fx, fy;
  logic              x_go;
  logic signed [9:0] mx_next, my_next;
  logic [19:0]       idx_full;
  logic [63:0]       perp_raw;
  logic [23:0]       perp_c;
  logic signed [RD_W-1:0] rd_sel;
  logic [15:0]       frac;
  logic [24:0]       tex_full;
  logic [8:0]        tex_raw, tex_m;
  logic              mirror;
  logic signed [13:0] ds, de;
  logic              hit_now;
  logic              accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign tex_row_start = '0;

  // Axis setup terms
  assign rdx_neg = rdx[RD_W-1];
  assign rdy_neg = rdy[RD_W-1];
  assign magx    = rdx_neg ? RD_W'(-rdx) : RD_W'(rdx);
  assign magy    = rdy_neg ? RD_W'(-rdy) : RD_W'(rdy);
  assign fx      = rdx_neg ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
  assign fy      = rdy_neg ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};

  // Grid step choice and next cell
  assign x_go    = sdx < sdy;
  assign mx_next = x_go ? (rdx_neg ? mx - 10'sd1 : mx + 10'sd1) : mx;
  assign my_next = x_go ? my : (rdy_neg ? my - 10'sd1 : my + 10'sd1);
  assign idx_full = 20'(mx_next) * 20'(MAP_H) + 20'(my_next);
  assign rd_idx   = idx_full[MEM_AW-1:0];
  assign hit_now  = oob || (rd_tile == TILE_WALL);

  // Perpendicular distance with clamping
  assign perp_raw = side ? sdy - 64'(ddy) : sdx - 64'(ddx);
  always_comb begin
    if (perp_raw < 64'(MIN_DIST))      perp_c = MIN_DIST;
    else if (perp_raw > 64'(DIST_MAX)) perp_c = DIST_MAX;
    else                               perp_c = perp_raw[23:0];
  end

  // Texture column from the hit coordinate
  assign rd_sel   = side ? rdx : rdy;
  assign frac     = (side ? cfg.pos_x[15:0] : cfg.pos_y[15:0]) + prod[31:16];
  assign tex_full = 25'(frac) * 25'(TEX_W);
  assign tex_raw  = tex_full[24:16];
  assign mirror   = (!side && !rdx_neg && rdx != '0) || (side && rdy_neg);
  assign tex_m    = mirror ? 9'(TEX_W - 1) - tex_raw : tex_raw;

  // Draw rows around the shifted horizon
  assign ds = 14'sd0 + 14'(SCREEN_H / 2) + 14'(cfg.horizon) - 14'(lh[11:1]);
  assign de = 14'sd0 + 14'(SCREEN_H / 2) + 14'(cfg.horizon) + 14'(lh[11:1]);

  // Multiplier operand select, product registered
  always_comb begin
    mul_a = 35'(rd_sel);
    mul_b = 25'($signed({1'b0, perp}));
    unique case (state)
      S_MPX:   begin mul_a = 35'(cam); mul_b = 25'(cfg.plane_x); end
      S_MPY:   begin mul_a = 35'(cam); mul_b = 25'(cfg.plane_y); end
      S_XMUL:  begin mul_a = $signed({2'b0, ddx[32:0]}); mul_b = $signed({8'b0, fx}); end
      S_YMUL:  begin mul_a = $signed({2'b0, ddy[32:0]}); mul_b = $signed({8'b0, fy}); end
      S_PERP:  begin mul_a = 35'(rd_sel); mul_b = 25'($signed({1'b0, perp_c})); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_IDLE: begin
        div_start = accept && (op == OP_CAST);
        div_num   = DIV_NW'({column, 17'b0});
        div_den   = DIV_DW'(SCREEN_W);
      end
      S_XGO: begin
        div_start = (rdx != '0);
        div_num   = 33'h1_0000_0000;
        div_den   = magx;
      end
      S_YGO: begin
        div_start = (rdy != '0);
        div_num   = 33'h1_0000_0000;
        div_den   = magy;
      end
      S_PERP: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(SCREEN_H) << 16;
        div_den   = DIV_DW'(perp_c);
      end
      S_TSGO: begin
        div_start = (lh != '0);
        div_num   = DIV_NW'(TEX_ROWS) << 16;
        div_den   = DIV_DW'(lh);
      end
      S_SHGO: begin
        div_start = 1'b1;
        div_num   = side ? SHADE_NUM_Y : SHADE_NUM_X;
        div_den   = SHADE_BIAS + DIV_DW'(perp);
      end
      default: ;
    endcase
  end

  ddac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Tile map write and registered read
  always_ff @(posedge clk) begin
    if (accept && op == OP_WRITE && 32'(cell_addr) < 32'(CELLS))
      tile_map[cell_addr[MEM_AW-1:0]] <= cell_tile;
    rd_tile <= tile_map[rd_idx];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE:  if (accept && op == OP_CAST) state <= S_CAM;
        S_CAM:   if (div_done) state <= S_MPX;
        S_MPX:   state <= S_MPY;
        S_MPY:   state <= S_XGO;
        S_XGO:   state <= (rdx != '0) ? S_XDIV : S_YGO;
        S_XDIV:  if (div_done) state <= S_XMUL;
        S_XMUL:  state <= S_XSD;
        S_XSD:   state <= S_YGO;
        S_YGO:   state <= (rdy != '0) ? S_YDIV : S_STEP;
        S_YDIV:  if (div_done) state <= S_YMUL;
        S_YMUL:  state <= S_YSD;
        S_YSD:   state <= S_STEP;
        S_STEP:  state <= S_CHECK;
        S_CHECK: state <= (hit_now || iter == IT_W'(MAX_STEPS)) ? S_PERP : S_STEP;
        S_PERP:  state <= S_LH;
        S_LH:    if (div_done) state <= S_TSGO;
        S_TSGO:  state <= (lh != '0) ? S_TS : S_SHGO;
        S_TS:    if (div_done) state <= S_SHGO;
        S_SHGO:  state <= S_SH;
        S_SH: begin
          if (div_done) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_CAM: if (div_done) cam <= $signed(div_quot[CAM_W-1:0]) - 24'sd65536;
      S_MPY: rdx <= RD_W'(cfg.dir_x) + prod[RD_W+15:16];
      S_XGO: begin
        rdy  <= RD_W'(cfg.dir_y) + prod[RD_W+15:16];
        mx   <= 10'(cfg.pos_x[20:16]);
        my   <= 10'(cfg.pos_y[20:16]);
        iter <= '0;
        hit  <= 1'b0;
        side <= 1'b0;
        if (rdx == '0) begin
          ddx <= 57'h100_0000_0000_0000;
          sdx <= 64'(fx) << 40;
        end
      end
      S_XDIV: if (div_done) ddx <= 57'(div_quot);
      S_XSD:  sdx <= 64'(prod[49:16]);
      S_YGO: begin
        if (rdy == '0) begin
          ddy <= 57'h100_0000_0000_0000;
          sdy <= 64'(fy) << 40;
        end
      end
      S_YDIV: if (div_done) ddy <= 57'(div_quot);
      S_YSD:  sdy <= 64'(prod[49:16]);
      S_STEP: begin
        if (x_go) sdx <= sdx + 64'(ddx);
        else      sdy <= sdy + 64'(ddy);
        side <= !x_go;
        mx   <= mx_next;
        my   <= my_next;
        oob  <= (mx_next < 10'sd0) || (mx_next >= 10'(MAP_W)) ||
                (my_next < 10'sd0) || (my_next >= 10'(MAP_H));
        iter <= iter + 1'b1;
      end
      S_CHECK: hit <= hit_now;
      S_PERP:  perp <= perp_c;
      S_LH: begin
        if (div_done) begin
          lh         <= (div_quot > DIV_NW'(LINE_MAX)) ? LINE_MAX : div_quot[11:0];
          tex_column <= tex_m[5:0];
        end
      end
      S_TSGO: if (lh == '0) tex_row_step <= DIST_MAX;
      S_TS:   if (div_done) tex_row_step <= div_quot[23:0];
      S_SH: begin
        if (div_done) begin
          shade       <= div_quot[7:0];
          wall_dist   <= perp;
          wall_side   <= side;
          wall_found  <= hit;
          line_height <= lh;
          if (ds < 14'sd0)                       top_row <= '0;
          else if (ds > 14'(SCREEN_H - 1))       top_row <= 8'(SCREEN_H - 1);
          else                                   top_row <= ds[7:0];
          if (de < 14'sd0)                       bottom_row <= '0;
          else if (de > 14'(SCREEN_H - 1))       bottom_row <= 8'(SCREEN_H - 1);
          else                                   bottom_row <= de[7:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/dda_wall_column_caster_top.sv -----
// Top level: camera configuration registers around the cast sequencer.
//
//  channel   | handshake        | fields
//  ----------+------------------+-------------------------------------------
//  command   | start / busy     | op, cell_addr, cell_tile, column
//  result    | done (strobe)    | wall_dist .. shade, one beat per cast
//  config    | cfg_we           | cfg_index, cfg_data
//
// A map write leaves busy low. A cast holds busy through three to six
// divisions on the one shared divider (a ray axis with a zero component and
// a zero line height skip theirs), the setup and handoff states, and a step
// state and a check state for each grid step.
// The result beat is shown in the same cycle that busy falls.
// Synchronous reset returns the sequencer to idle and loads the camera
// defaults; the tile map holds no reset value. The receiver cannot stall:
// each result beat is shown for exactly the one cycle that done is high.
module dda_wall_column_caster_top #(
  parameter int MAP_W     = 32,
  parameter int MAP_H     = 32,
  parameter int SCREEN_W  = 396,
  parameter int SCREEN_H  = 224,
  parameter int TEX_W     = 64,
  parameter int MAX_STEPS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [9:0]         cell_addr,
  input  logic [1:0]         cell_tile,
  input  logic [8:0]         column,
  output logic               done,
  output logic [23:0]        wall_dist,
  output logic               wall_side,
  output logic               wall_found,
  output logic [5:0]         tex_column,
  output logic [11:0]        line_height,
  output logic [7:0]         top_row,
  output logic [7:0]         bottom_row,
  output logic [23:0]        tex_row_step,
  output logic signed [23:0] tex_row_start,
  output logic [7:0]         shade,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [20:0]        cfg_data
);
  import ddac_pkg::*;

  cam_cfg_t cfg;

  // Camera register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x   <= 21'd98304;
      cfg.pos_y   <= 21'd1081344;
      cfg.dir_x   <= 18'sd65536;
      cfg.dir_y   <= '0;
      cfg.plane_x <= '0;
      cfg.plane_y <= 18'sd43254;
      cfg.horizon <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_POS_X:     cfg.pos_x   <= cfg_data;
        REG_CAM_POS_Y:     cfg.pos_y   <= cfg_data;
        REG_VIEW_DIR_X:    cfg.dir_x   <= $signed(cfg_data[17:0]);
        REG_VIEW_DIR_Y:    cfg.dir_y   <= $signed(cfg_data[17:0]);
        REG_CAM_PLANE_X:   cfg.plane_x <= $signed(cfg_data[17:0]);
        REG_CAM_PLANE_Y:   cfg.plane_y <= $signed(cfg_data[17:0]);
        REG_HORIZON_SHIFT: cfg.horizon <= $signed(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  ddac_core #(
    .MAP_W     (MAP_W),
    .MAP_H     (MAP_H),
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H),
    .TEX_W     (TEX_W),
    .MAX_STEPS (MAX_STEPS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .cell_addr     (cell_addr),
    .cell_tile     (cell_tile),
    .column        (column),
    .done          (done),
    .wall_dist     (wall_dist),
    .wall_side     (wall_side),
    .wall_found    (wall_found),
    .tex_column    (tex_column),
    .line_height   (line_height),
    .top_row       (top_row),
    .bottom_row    (bottom_row),
    .tex_row_step  (tex_row_step),
    .tex_row_start (tex_row_start),
    .shade         (shade)
  );

endmodule

// ----- design/ddac_check.sv -----
// Port-level checker for the caster, bound to the top level.
module ddac_check (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        op,
  input logic        done,
  input logic [23:0] wall_dist,
  input logic [7:0]  top_row,
  input logic [7:0]  bottom_row
);
  import ddac_pkg::*;

  // A result beat always lands with the sequencer back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  // An accepted cast occupies the block
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_CAST) |=> busy) else $error("cast not started");

  // A map write finishes at once and yields no result
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_WRITE) |=> (!busy && !done))
    else $error("map write disturbed the sequencer");

  // Distance is clamped from below
  a_min_dist: assert property (@(posedge clk) disable iff (rst)
    done |-> (wall_dist >= MIN_DIST)) else $error("distance below minimum");

  // Draw span is ordered
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (top_row <= bottom_row)) else $error("top row below bottom row");

endmodule

bind dda_wall_column_caster_top ddac_check u_ddac_check (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .op         (op),
  .done       (done),
  .wall_dist  (wall_dist),
  .top_row    (top_row),
  .bottom_row (bottom_row)
);
